### hw/rtl/tcc_pkg.sv
// Shared types, constants and index helper for the text console cursor engine.
// No dependencies; every other file in hw/rtl imports this package.
package tcc_pkg;

   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 8;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int IDX_W  = 11;
   localparam int CELL_W = 16;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_SCROLL = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic REQ_PUT   = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0] ATTR_RESET = 8'h0F;

   typedef struct packed {
      logic       req_type;
      logic [7:0] char_code;
   } tcc_req_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [IDX_W-1:0]  cell_index;
      logic [CELL_W-1:0] cell_value;
      logic [IDX_W-1:0]  cursor_index;
      logic              cursor_update;
      logic              last;
   } tcc_rsp_type;

   typedef struct packed {
      tcc_rsp_type      first;
      tcc_rsp_type      second;
      logic             two;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } tcc_step_type;

   function automatic logic [IDX_W-1:0] lin_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [IDX_W:0] prod;
      prod = (IDX_W+1)'(row) * (IDX_W+1)'(COLUMNS) + (IDX_W+1)'(col);
      return prod[IDX_W-1:0];
   endfunction

endpackage

### hw/rtl/tcc_step.sv
// Cursor update and command generation for one request.
// Depends on tcc_pkg.
module tcc_step import tcc_pkg::*; (
   input  tcc_req_type      req,
   input  logic [COL_W-1:0] col_cur,
   input  logic [ROW_W-1:0] row_cur,
   input  logic [7:0]       attr,
   output tcc_step_type     step
);

   logic [COL_W:0]     col_n;
   logic [ROW_W:0]     row_n;
   logic               wrote;
   logic               bs_origin;
   logic               scrolled;
   logic [IDX_W-1:0]   widx;
   logic [CELL_W-1:0]  wval;
   logic [CELL_W-1:0]  blank;
   logic [IDX_W-1:0]   cur;
   logic [COL_W-1:0]   col_f;
   logic [ROW_W-1:0]   row_f;

   assign blank = {attr, CH_SPACE};

   always_comb begin
      col_n     = {1'b0, col_cur};
      row_n     = {1'b0, row_cur};
      wrote     = 1'b0;
      bs_origin = 1'b0;
      widx      = '0;
      wval      = '0;
      if (req.char_code == CH_BS) begin
         if (col_cur == '0 && row_cur == '0) begin
            bs_origin = 1'b1;
         end else begin
            if (col_cur == '0) begin
               col_n = (COL_W+1)'(COLUMNS - 1);
               row_n = row_n - 1'b1;
            end else begin
               col_n = col_n - 1'b1;
            end
            wrote = 1'b1;
            widx  = lin_index(row_n[ROW_W-1:0], col_n[COL_W-1:0]);
            wval  = blank;
         end
      end else if (req.char_code == CH_TAB) begin
         col_n = col_n + (COL_W+1)'(TAB_WIDTH) - (col_n % (COL_W+1)'(TAB_WIDTH));
      end else if (req.char_code == CH_CR) begin
         col_n = '0;
      end else if (req.char_code == CH_LF) begin
         col_n = '0;
         row_n = row_n + 1'b1;
      end else if (req.char_code >= CH_SPACE) begin
         wrote = 1'b1;
         widx  = lin_index(row_cur, col_cur);
         wval  = {attr, req.char_code};
         col_n = col_n + 1'b1;
      end

      if (col_n >= (COL_W+1)'(COLUMNS)) begin
         col_n = '0;
         row_n = row_n + 1'b1;
      end

      scrolled = 1'b0;
      if (row_n >= (ROW_W+1)'(ROWS)) begin
         row_n    = (ROW_W+1)'(ROWS - 1);
         scrolled = 1'b1;
      end
   end

   assign col_f = col_n[COL_W-1:0];
   assign row_f = row_n[ROW_W-1:0];
   assign cur   = lin_index(row_f, col_f);

   always_comb begin
      step.two    = 1'b0;
      step.col    = col_f;
      step.row    = row_f;
      step.second = '{action: ACT_SCROLL, cell_index: '0, cell_value: blank,
                      cursor_index: cur, cursor_update: 1'b1, last: 1'b1};
      step.first  = '{action: ACT_NONE, cell_index: '0, cell_value: '0,
                      cursor_index: cur, cursor_update: 1'b1, last: 1'b1};
      if (req.req_type == REQ_CLEAR) begin
         step.col   = '0;
         step.row   = '0;
         step.first = '{action: ACT_CLEAR, cell_index: '0, cell_value: blank,
                        cursor_index: '0, cursor_update: 1'b1, last: 1'b1};
      end else if (bs_origin) begin
         step.col   = col_cur;
         step.row   = row_cur;
         step.first = '{action: ACT_NONE, cell_index: '0, cell_value: '0,
                        cursor_index: '0, cursor_update: 1'b0, last: 1'b1};
      end else if (wrote) begin
         step.two   = scrolled;
         step.first = '{action: ACT_WRITE, cell_index: widx, cell_value: wval,
                        cursor_index: cur, cursor_update: !scrolled,
                        last: !scrolled};
      end else if (scrolled) begin
         step.first = step.second;
      end
   end

endmodule

### hw/rtl/text_console_cursor_engine.sv
// Text console cursor engine: one character or clear request in, cell commands out.
// Latency: a result is presented the cycle after its request transfer.
// Throughput: one request per cycle unless rsp_ready is low or a scroll is pending.
// Reset (synchronous): cursor at origin, attribute 0x0F, no results pending.
// Depends on tcc_pkg and tcc_step.
module text_console_cursor_engine import tcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tcc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tcc_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [7:0]       attr_ff;
   logic             a_valid_ff, a_valid_in;
   logic             b_valid_ff, b_valid_in;
   tcc_rsp_type      a_ff, a_in;
   tcc_rsp_type      b_ff, b_in;
   tcc_step_type     step;
   logic             req_xfer;
   logic             rsp_xfer;

   tcc_step u_step (
      .req     (req_data),
      .col_cur (col_ff),
      .row_cur (row_ff),
      .attr    (attr_ff),
      .step    (step)
   );

   assign csr_ready = 1'b1;
   assign req_ready = !b_valid_ff && (!a_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = a_valid_ff && rsp_ready;
   assign rsp_valid = a_valid_ff;
   assign rsp_data  = a_ff;

   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      if (req_xfer) begin
         a_valid_in = 1'b1;
         a_in       = step.first;
         b_valid_in = step.two;
         b_in       = step.second;
      end else if (rsp_xfer) begin
         // advance the pending scroll into the output slot
         a_valid_in = b_valid_ff;
         a_in       = b_ff;
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         attr_ff    <= ATTR_RESET;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         if (req_xfer) begin
            col_ff <= step.col;
            row_ff <= step.row;
         end
         if (csr_valid) begin
            attr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

### tb/testbench.sv
// Self-checking testbench for text_console_cursor_engine: directed and random character traffic,
// with an in-bench cursor predictor checked against every result transfer.
// Depends on tcc_pkg and the engine RTL.
`timescale 1ns / 100ps

module testbench import tcc_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tcc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tcc_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   tcc_rsp_type expected_cells[$];
   logic [7:0]  text_attr = ATTR_RESET;
   int          cons_col = 0;
   int          cons_row = 0;
   int          failures = 0;
   int          results_seen = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   text_console_cursor_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic record_failure(input string msg);
      failures++;
      if (failures <= 10) $display("mismatch at result %0d: %s", results_seen, msg);
   endtask

   task automatic predict_console(input tcc_req_type item);
      int          col;
      int          row;
      int          cell_idx;
      int          cur;
      logic [15:0] blank;
      logic [15:0] wval;
      bit          wrote;
      bit          scrolled;
      tcc_rsp_type r;
      col = cons_col;
      row = cons_row;
      cell_idx = 0;
      wval = '0;
      wrote = 1'b0;
      scrolled = 1'b0;
      blank = {text_attr, CH_SPACE};
      r = '0;
      r.last = 1'b1;
      if (item.req_type == REQ_CLEAR) begin
         cons_col = 0;
         cons_row = 0;
         r.action = ACT_CLEAR;
         r.cell_value = blank;
         r.cursor_update = 1'b1;
         expected_cells.push_back(r);
      end else if (item.char_code == CH_BS && col == 0 && row == 0) begin
         r.action = ACT_NONE;
         expected_cells.push_back(r);
      end else begin
         if (item.char_code == CH_BS) begin
            if (col == 0) begin
               col = COLUMNS - 1;
               row--;
            end else begin
               col--;
            end
            wrote = 1'b1;
            cell_idx = row * COLUMNS + col;
            wval = blank;
         end else if (item.char_code == CH_TAB) begin
            col = col + TAB_WIDTH - (col % TAB_WIDTH);
         end else if (item.char_code == CH_CR) begin
            col = 0;
         end else if (item.char_code == CH_LF) begin
            col = 0;
            row++;
         end else if (item.char_code >= CH_SPACE) begin
            wrote = 1'b1;
            cell_idx = row * COLUMNS + col;
            wval = {text_attr, item.char_code};
            col++;
         end
         if (col >= COLUMNS) begin
            col = 0;
            row++;
         end
         if (row >= ROWS) begin
            row = ROWS - 1;
            scrolled = 1'b1;
         end
         cons_col = col;
         cons_row = row;
         cur = row * COLUMNS + col;
         r.cursor_index = cur[IDX_W-1:0];
         if (wrote) begin
            r.action = ACT_WRITE;
            r.cell_index = cell_idx[IDX_W-1:0];
            r.cell_value = wval;
            r.cursor_update = !scrolled;
            r.last = !scrolled;
            expected_cells.push_back(r);
         end
         if (scrolled) begin
            r.action = ACT_SCROLL;
            r.cell_index = '0;
            r.cell_value = blank;
            r.cursor_update = 1'b1;
            r.last = 1'b1;
            expected_cells.push_back(r);
         end
         if (!wrote && !scrolled) begin
            r.action = ACT_NONE;
            r.cursor_update = 1'b1;
            expected_cells.push_back(r);
         end
      end
   endtask

   // Handshakes are stable between the falling edge and the next rising edge.
   always @(negedge clock) begin
      tcc_rsp_type want;
      tcc_rsp_type got;
      if (!reset) begin
         if (req_valid && req_ready) predict_console(req_data);
         if (csr_valid && csr_ready) text_attr = csr_data;
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            results_seen++;
            if (expected_cells.size() == 0) begin
               record_failure($sformatf("unexpected result action %0d cell %0d", got.action,
                                        got.cell_index));
            end else begin
               want = expected_cells.pop_front();
               if (got.action !== want.action)
                  record_failure($sformatf("action exp %0d got %0d", want.action, got.action));
               if (got.cell_index !== want.cell_index)
                  record_failure($sformatf("cell_index exp %0d got %0d", want.cell_index,
                                           got.cell_index));
               if (got.cell_value !== want.cell_value)
                  record_failure($sformatf("cell_value exp %h got %h", want.cell_value,
                                           got.cell_value));
               if (got.cursor_index !== want.cursor_index)
                  record_failure($sformatf("cursor_index exp %0d got %0d", want.cursor_index,
                                           got.cursor_index));
               if (got.cursor_update !== want.cursor_update)
                  record_failure($sformatf("cursor_update exp %0d got %0d", want.cursor_update,
                                           got.cursor_update));
               if (got.last !== want.last)
                  record_failure($sformatf("last exp %0d got %0d", want.last, got.last));
            end
         end
      end
   end

   task automatic send_request(input logic kind, input logic [7:0] code);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: kind, char_code: code};
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_text_attribute(input logic [7:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_state_and_controls();
      send_request(REQ_PUT, CH_BS);
      send_request(REQ_PUT, 8'h41);
      send_request(REQ_PUT, 8'hFF);
      send_request(REQ_PUT, 8'h7F);
      send_request(REQ_PUT, CH_SPACE);
      send_request(REQ_PUT, CH_BS);
      send_request(REQ_PUT, CH_TAB);
      send_request(REQ_PUT, CH_TAB);
      send_request(REQ_PUT, CH_CR);
      send_request(REQ_PUT, 8'h00);
      send_request(REQ_PUT, 8'h1F);
      send_request(REQ_PUT, 8'h1B);
      send_request(REQ_PUT, CH_LF);
      send_request(REQ_PUT, CH_BS);
      send_request(REQ_CLEAR, 8'hFF);
      send_request(REQ_CLEAR, 8'h00);
      send_request(REQ_PUT, CH_BS);
      repeat (10) send_request(REQ_PUT, CH_TAB);
   endtask

   task automatic test_screen_edges();
      send_request(REQ_CLEAR, 8'h5A);
      repeat (ROWS) send_request(REQ_PUT, CH_LF);
      repeat (9) send_request(REQ_PUT, CH_TAB);
      for (int i = 0; i < 7; i++) send_request(REQ_PUT, 8'(8'h61 + i));
      send_request(REQ_PUT, 8'h5A);
      send_request(REQ_PUT, CH_BS);
      send_request(REQ_PUT, 8'h71);
      send_request(REQ_PUT, CH_BS);
      send_request(REQ_PUT, CH_TAB);
      send_request(REQ_PUT, CH_CR);
   endtask

   task automatic run_random_phase(input int count, input int send_pct, input int stall_pct,
                                   input logic [7:0] attr);
      int pick;
      write_text_attribute(attr);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 399);
         if (pick < 1)
            send_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
         else if (pick < 40)
            send_request(REQ_PUT, CH_BS);
         else if (pick < 70)
            send_request(REQ_PUT, CH_TAB);
         else if (pick < 86)
            send_request(REQ_PUT, CH_CR);
         else if (pick < 134)
            send_request(REQ_PUT, CH_LF);
         else if (pick < 154)
            send_request(REQ_PUT, 8'($urandom_range(0, 31)));
         else
            send_request(REQ_PUT, 8'($urandom_range(32, 255)));
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(400, 0, 0, 8'h00);
      run_random_phase(400, 62, 0, 8'hFF);
      run_random_phase(400, 0, 62, 8'($urandom_range(0, 255)));
      run_random_phase(400, 20, 20, 8'($urandom_range(0, 255)));
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state_and_controls();
      test_screen_edges();
      test_random_traffic();
      drain_results();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
